// File: rtl/core/hbls_pkg.sv
// Shared constants, command/status types and helpers for the hash bucket load statistics block.
package hbls_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int MAX_KEYS    = 1024;
    localparam int KEY_BITS    = 16;

    localparam int KEY_W  = 16;                       // key field width
    localparam int CFG_W  = 7;                        // bucket_count register width
    localparam int BKT_W  = $clog2(MAX_BUCKETS);      // bucket index
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);     // per-bucket count, total
    localparam int AVG_W  = 19;                       // average_q8 field width
    localparam int FRAC_W = 8;                        // Q.8 fraction bits
    localparam int DVD_W  = AVG_W;                    // shared divider dividend width
    localparam int REM_W  = CFG_W;                    // divider partial remainder
    localparam int DCNT_W = $clog2(DVD_W);            // divider step counter
    localparam int OUT_DATA_W = 64;                   // output tdata, whole bytes

    localparam logic [CNT_W-1:0] MAX_KEYS_C = CNT_W'(MAX_KEYS);
    localparam logic [CFG_W-1:0] MAX_BKT_C  = CFG_W'(MAX_BUCKETS);

    // controller -> datapath
    typedef struct packed {
        logic load;        // take a new key request
        logic div_step;    // one restoring-division step
        logic rd_bucket;   // read histogram entry of the hashed bucket
        logic wr_bucket;   // write back incremented entry, bump total
        logic scan_init;   // reset scan index
        logic scan_rd;     // read entry at scan index
        logic scan_acc;    // fold read entry into min/max, advance index
        logic avg_start;   // load total*256 into the divider
        logic clear;       // drop histogram and total after a report
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_last;    // current step is the final divider step
        logic last;        // request carries the batch-end mark
        logic scan_last;   // scan index is at the last live bucket
    } t_sts;

    // finished result handed to the output register
    typedef struct packed {
        logic [BKT_W-1:0] bucket;
        logic             stats_valid;
        logic [CNT_W-1:0] longest;
        logic [CNT_W-1:0] shortest;
        logic [CNT_W-1:0] key_total;
        logic [AVG_W-1:0] average_q8;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v < MAX_KEYS_C) ? v + CNT_W'(1) : MAX_KEYS_C;
    endfunction

    function automatic logic [CFG_W-1:0] eff_buckets(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] m;
        m = v;
        if (m == '0) m = CFG_W'(1);
        if (m > MAX_BKT_C) m = MAX_BKT_C;
        return m;
    endfunction

endpackage

// File: rtl/core/hbls_ctrl.sv
// Sequencing state machine: hash divide, histogram update, scan and average divide.
module hbls_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_out_free,
    input  hbls_pkg::t_sts i_sts,
    output hbls_pkg::t_cmd o_cmd,
    output logic          o_idle,
    output logic          o_out_load
);
    import hbls_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIVK  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_WR    = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SACC  = 3'd5;
    localparam logic [2:0] S_DIVA  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_accept;
                if (i_accept) n_state = S_DIVK;
            end
            S_DIVK: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd_bucket = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.wr_bucket = 1'b1;
                o_cmd.scan_init = 1'b1;
                n_state = i_sts.last ? S_SRD : S_DONE;
            end
            S_SRD: begin
                o_cmd.scan_rd = 1'b1;
                n_state = S_SACC;
            end
            S_SACC: begin
                o_cmd.scan_acc = 1'b1;
                n_state = i_sts.scan_last ? S_DIVA : S_SRD;
                o_cmd.avg_start = i_sts.scan_last;
            end
            S_DIVA: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_out_load  = 1'b1;
                    o_cmd.clear = i_sts.last;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// File: rtl/core/hbls_datapath.sv
// Datapath: shared restoring divider, histogram memory with valid bits, min/max scan.
module hbls_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hbls_pkg::t_cmd                i_cmd,
    input  logic [hbls_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_last,
    input  logic [hbls_pkg::CFG_W-1:0]    i_bucket_count,
    output hbls_pkg::t_sts                o_sts,
    output hbls_pkg::t_result             o_result
);
    import hbls_pkg::*;

    // request and divider registers
    logic              r_last;
    logic [CFG_W-1:0]  r_m;
    logic [DVD_W-1:0]  r_dvd;
    logic [REM_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;
    logic [BKT_W-1:0]  r_bucket;

    // histogram
    logic [CNT_W-1:0]       r_mem [MAX_BUCKETS];
    logic [MAX_BUCKETS-1:0] r_vld;
    logic [CNT_W-1:0]       r_rdata;
    logic                   r_rvld;
    logic [CNT_W-1:0]       r_total;

    // scan
    logic [BKT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_longest, r_shortest;

    logic [REM_W-1:0] rem_sh;
    logic             rem_ge;
    logic [CNT_W-1:0] cur_cnt;
    logic [KEY_W-1:0] key_m;
    logic [BKT_W-1:0] rd_addr;

    assign key_m   = i_key & KEY_W'((64'd1 << KEY_BITS) - 64'd1);
    assign rem_sh  = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
    assign rem_ge  = (rem_sh >= r_m);
    assign cur_cnt = r_rvld ? r_rdata : '0;
    assign rd_addr = i_cmd.scan_rd ? r_idx : r_rem[BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_last;
            r_m    <= eff_buckets(i_bucket_count);
            r_dvd  <= DVD_W'(key_m);
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(DVD_W - 1);
        end else if (i_cmd.avg_start) begin
            r_dvd  <= DVD_W'({r_total, {FRAC_W{1'b0}}});
            r_rem  <= '0;
            r_dcnt <= DCNT_W'(DVD_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem_sh - r_m : rem_sh;
            r_dvd  <= {r_dvd[DVD_W-2:0], rem_ge};
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    // histogram memory: registered read, one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_bucket || i_cmd.scan_rd) r_rdata <= r_mem[rd_addr];
        if (i_cmd.wr_bucket) r_mem[r_bucket] <= sat_inc(cur_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_bucket) r_bucket <= r_rem[BKT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rvld  <= 1'b0;
            r_total <= '0;
        end else begin
            if (i_cmd.rd_bucket || i_cmd.scan_rd) r_rvld <= r_vld[rd_addr];
            if (i_cmd.clear) begin
                r_vld   <= '0;
                r_total <= '0;
            end else if (i_cmd.wr_bucket) begin
                r_vld[r_bucket] <= 1'b1;
                r_total         <= sat_inc(r_total);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.scan_acc) begin
            r_idx <= r_idx + BKT_W'(1);
            if (r_idx == '0) begin
                r_longest  <= cur_cnt;
                r_shortest <= cur_cnt;
            end else begin
                if (cur_cnt > r_longest)  r_longest  <= cur_cnt;
                if (cur_cnt < r_shortest) r_shortest <= cur_cnt;
            end
        end
    end

    assign o_sts.div_last  = (r_dcnt == '0);
    assign o_sts.last      = r_last;
    assign o_sts.scan_last = ({1'b0, r_idx} == r_m - CFG_W'(1));

    assign o_result.bucket      = r_bucket;
    assign o_result.stats_valid = r_last;
    assign o_result.longest     = r_last ? r_longest  : '0;
    assign o_result.shortest    = r_last ? r_shortest : '0;
    assign o_result.key_total   = r_last ? r_total    : '0;
    assign o_result.average_q8  = r_last ? r_dvd      : '0;

endmodule

// File: rtl/core/hash_bucket_load_stats.sv
// Top level: division hash with per-bucket load histogram and batch statistics.
//
//  channel    | dir | handshake                    | payload
//  -----------+-----+------------------------------+-----------------------------------
//  s_axis     | in  | s_axis_tvalid/s_axis_tready  | tdata key, tlast batch end
//  m_axis     | out | m_axis_tvalid/m_axis_tready  | tdata bucket..average_q8, tuser
//  cfg        | in  | i_cfg_valid/o_cfg_ready      | bucket_count
//
// Sequence: a key request takes 19 divider steps (one quotient bit per cycle through
// the shared restoring divider), a histogram read, a write and the output load, which
// waits while the output register is full; the next request is taken only once the
// sequencer is back in idle. A batch-end request adds a scan of the live buckets, a
// read and a fold per bucket through the single histogram read port, and another
// 19-step divide for the average.
// Reset is synchronous, active low; the histogram valid bits clear at once, no sweep.
// A new request is taken while the previous result waits in the output register;
// the sequencer only holds in its final state if that register is still full.
module hash_bucket_load_stats (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] key
    input  logic        s_axis_tlast,   // last
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [5:0] bucket, [16:6] longest, [27:17] shortest,
                                        // [38:28] key_total, [57:39] average_q8, rest 0
    output logic        m_axis_tuser,   // stats_valid
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data      // bucket_count
);
    import hbls_pkg::*;

    logic [CFG_W-1:0] r_bucket_count;
    logic             r_out_valid;
    t_result          r_out;

    t_cmd    cmd;
    t_sts    sts;
    t_result result;
    logic    idle, out_load, out_free, in_accept;

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                       r_bucket_count <= CFG_W'(7);
        else if (i_cfg_valid && o_cfg_ready) r_bucket_count <= i_cfg_data;
    end

    assign s_axis_tready = idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    hbls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_out_load (out_load)
    );

    hbls_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_key          (s_axis_tdata),
        .i_last         (s_axis_tlast),
        .i_bucket_count (r_bucket_count),
        .o_sts          (sts),
        .o_result       (result)
    );

    // output register: decouples the sequencer from downstream stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_out_valid <= 1'b0;
        else if (out_load) r_out_valid <= 1'b1;
        else if (m_axis_tready) r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out <= result;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.stats_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out.average_q8, r_out.key_total,
                                        r_out.shortest, r_out.longest, r_out.bucket});

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the division hash bucket load statistics block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbls_pkg::*;

    // Slowest legal run: ~1550 requests, some with a batch-end scan of 64 buckets,
    // plus gaps and stalls on both sides; CYCLE_LIMIT allows ~3x that.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 250;    // longer than one batch-end request
    localparam int REPORT_MAX   = 10;
    localparam int CFG_BUCKET_COUNT = 0;  // only register on the config channel

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] key
    logic        s_axis_tlast = 1'b0;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // [5:0] bucket, [16:6] longest, [27:17] shortest,
                                        // [38:28] key_total, [57:39] average_q8
    logic        m_axis_tuser;          // stats_valid
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;       // bucket_count

    hash_bucket_load_stats i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the block state: histogram, running batch total, register.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] bucket_count_cfg = CFG_W'(7);
    logic [CNT_W-1:0] bucket_load [MAX_BUCKETS];
    logic [CNT_W-1:0] batch_keys;
    t_result          pending_results [$];

    int  mismatches   = 0;
    int  cycles       = 0;
    bit  idle_en      = 1'b1;   // random bursts of idle on both sides
    int  rx_hold_len  = 0;      // one-shot long stall for the receiver

    initial begin
        foreach (bucket_load[i]) bucket_load[i] = '0;
        batch_keys = '0;
    end

    // register value as the hash sees it: 0 acts as 1, above MAX_BUCKETS clamps
    function automatic int live_buckets(input logic [CFG_W-1:0] cfg);
        if (cfg == '0) return 1;
        if (int'(cfg) > MAX_BUCKETS) return MAX_BUCKETS;
        return int'(cfg);
    endfunction

    // Hash one key into the histogram; on a batch end also fold the live
    // buckets into min/max, report total and Q.8 average, then clear.
    function automatic t_result hash_and_count(input logic [KEY_W-1:0] key,
                                               input logic last);
        t_result r;
        int      m;
        int      b;
        int      hi;
        int      lo;
        m = live_buckets(bucket_count_cfg);
        b = int'(key) % m;
        r = '0;
        r.bucket = BKT_W'(b);
        bucket_load[b] = (bucket_load[b] < CNT_W'(MAX_KEYS)) ? bucket_load[b] + 1'b1
                                                             : CNT_W'(MAX_KEYS);
        batch_keys = (batch_keys < CNT_W'(MAX_KEYS)) ? batch_keys + 1'b1 : CNT_W'(MAX_KEYS);
        if (last) begin
            hi = bucket_load[0];
            lo = bucket_load[0];
            for (int i = 1; i < m; i++) begin
                if (bucket_load[i] > hi) hi = bucket_load[i];
                if (bucket_load[i] < lo) lo = bucket_load[i];
            end
            r.stats_valid = 1'b1;
            r.longest     = CNT_W'(hi);
            r.shortest    = CNT_W'(lo);
            r.key_total   = batch_keys;
            r.average_q8  = AVG_W'((int'(batch_keys) * 256) / m);
            // whole histogram goes, not just the live part
            foreach (bucket_load[i]) bucket_load[i] = '0;
            batch_keys = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one key request, optional idle burst before it.
    // ------------------------------------------------------------------
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);   // junk while idle must be ignored
            s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(hash_and_count(key, last));
    endtask

    // Stop sending and wait until every predicted result has been seen.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Register write, only with the block idle; every request yields a
    // result, so an empty expectation queue means nothing is in flight.
    task automatic set_bucket_count(input logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (CFG_BUCKET_COUNT == 0) bucket_count_cfg = value;
    endtask

    function automatic logic [CFG_W-1:0] pick_bucket_count();
        case ($urandom_range(0, 9))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(MAX_BUCKETS);
            3: return CFG_W'(MAX_BUCKETS + 1);
            4: return CFG_W'(127);
            5: return CFG_W'($urandom_range(0, 127));
            default: return CFG_W'($urandom_range(2, MAX_BUCKETS));
        endcase
    endfunction

    // Random key, biased toward bucket wrap points of the current count.
    function automatic logic [KEY_W-1:0] pick_key();
        int m;
        m = live_buckets(bucket_count_cfg);
        if ($urandom_range(0, 3) == 0)
            return KEY_W'(m * $urandom_range(0, 65535 / m) + $urandom_range(0, 1) * (m - 1));
        return KEY_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: ready with random stall bursts, plus an optional long hold.
    // ------------------------------------------------------------------
    always begin : result_ready
        @(posedge i_clk);
        if (rx_hold_len > 0) begin
            m_axis_tready <= 1'b0;
            repeat (rx_hold_len) @(posedge i_clk);
            rx_hold_len = 0;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.bucket      = m_axis_tdata[5:0];
            got.longest     = m_axis_tdata[16:6];
            got.shortest    = m_axis_tdata[27:17];
            got.key_total   = m_axis_tdata[38:28];
            got.average_q8  = m_axis_tdata[57:39];
            got.stats_valid = m_axis_tuser;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result with nothing expected: bucket=%0d stats=%0b",
                             $realtime, got.bucket, got.stats_valid);
            end else begin
                want = pending_results.pop_front();
                if (got.bucket !== want.bucket || got.stats_valid !== want.stats_valid ||
                    got.longest !== want.longest || got.shortest !== want.shortest ||
                    got.key_total !== want.key_total ||
                    got.average_q8 !== want.average_q8) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: mismatch exp bkt=%0d sv=%0b max=%0d min=%0d tot=%0d avg=%0d",
                                 $realtime, want.bucket, want.stats_valid, want.longest,
                                 want.shortest, want.key_total, want.average_q8);
                        $display("%0t:          got bkt=%0d sv=%0b max=%0d min=%0d tot=%0d avg=%0d",
                                 $realtime, got.bucket, got.stats_valid, got.longest,
                                 got.shortest, got.key_total, got.average_q8);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset count of 7: key extremes, bucket wrap, alternating bit patterns.
    task automatic test_reset_count_extremes();
        send_key(16'h0000, 1'b0);
        send_key(16'hFFFF, 1'b0);
        send_key(16'd7, 1'b0);
        send_key(16'd6, 1'b0);
        send_key(16'hAAAA, 1'b0);
        send_key(16'h5555, 1'b1);
    endtask

    // Register extremes: 0 acts as 1, above 64 clamps, single-key batch.
    task automatic test_count_range();
        set_bucket_count(CFG_W'(0));
        send_key(16'hFFFF, 1'b0);
        send_key(16'd12345, 1'b1);
        set_bucket_count(CFG_W'(127));
        send_key(16'd63, 1'b0);
        send_key(16'd64, 1'b0);
        send_key(16'hFFFF, 1'b1);
        set_bucket_count(CFG_W'(MAX_BUCKETS + 1));
        send_key(16'hFFC0, 1'b1);
        set_bucket_count(CFG_W'(1));
        send_key(16'h8000, 1'b0);
        send_key(16'h7FFF, 1'b1);
        set_bucket_count(CFG_W'(MAX_BUCKETS));
        send_key(16'd127, 1'b0);
        send_key(16'd1, 1'b1);
    endtask

    // Count changed inside an open batch: old buckets stay, scan uses new count.
    task automatic test_midbatch_reconfig();
        set_bucket_count(CFG_W'(MAX_BUCKETS));
        send_key(16'd63, 1'b0);
        send_key(16'd10, 1'b0);
        send_key(16'd1, 1'b0);
        set_bucket_count(CFG_W'(3));
        send_key(16'd5, 1'b1);
    endtask

    // One bucket, more keys than MAX_KEYS: bucket count and total saturate.
    task automatic test_saturation();
        set_bucket_count(CFG_W'(1));
        for (int k = 0; k < MAX_KEYS + 16; k++)
            send_key(pick_key(), k == MAX_KEYS + 15);
    endtask

    // Receiver stalls for a long time while keys keep coming; the block
    // must fill up and hold its input. Then the sender waits for a drain.
    task automatic test_backpressure();
        set_bucket_count(CFG_W'(2));
        rx_hold_len = 300;
        for (int k = 0; k < 16; k++)
            send_key(pick_key(), k == 15);
        drain_results();
    endtask

    // Random batches, mostly short, some long; count reprogrammed between
    // batches and now and then in the middle of one.
    task automatic test_random_batches(input int n_keys);
        int sent;
        int len;
        sent = 0;
        while (sent < n_keys) begin
            if ($urandom_range(0, 2) == 0) set_bucket_count(pick_bucket_count());
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
            for (int k = 0; k < len; k++) begin
                if (len > 2 && k == len / 2 && $urandom_range(0, 9) == 0)
                    set_bucket_count(pick_bucket_count());
                send_key(pick_key(), k == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin : main
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_count_extremes();
        test_count_range();
        test_midbatch_reconfig();
        test_saturation();
        test_backpressure();
        test_random_batches(420);
        // last stretch runs back to back on both sides
        drain_results();
        idle_en = 1'b0;
        test_random_batches(60);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        mismatches += pending_results.size();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
